/* hw/rtl/sfce_pkg.sv */
// Shared types, constants and the byte-wise CRC-16 update for the scope frame encoder.
`default_nettype none

package sfce_pkg;

    localparam int unsigned SAMPLE_W    = 16;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CRC_W       = 16;
    localparam int unsigned DATA_BYTES  = 8;
    localparam int unsigned FRAME_BYTES = 10;
    localparam int unsigned IDX_W       = $clog2(FRAME_BYTES);

    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

    localparam logic [IDX_W-1:0] IDX_FIRST    = IDX_W'(0);
    localparam logic [IDX_W-1:0] IDX_CRC_LOW  = IDX_W'(DATA_BYTES);
    localparam logic [IDX_W-1:0] IDX_CRC_HIGH = IDX_W'(FRAME_BYTES - 1);

    typedef logic [BYTE_W-1:0] byte_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic crc_step;
    } sfce_ctrl_t;

    function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc_in,
                                                   input byte_t data_in);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data_in};
        for (int b = 0; b < BYTE_W; b++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/scope_frame_crc16_encoder_unit.sv */
// Top level of the scope frame encoder: input buffer, byte chain, CRC unit and output control.
`default_nettype none

// Each accepted word of four 16-bit samples produces a ten-byte frame on the output: the
// low then high byte of samples a, b, c and d, then the CRC-16/MODBUS of those eight bytes,
// low byte first, with frame_end set on the last byte. Bytes leave at one per cycle while
// the output does not stall. The eight-cell byte chain shifts one byte toward the output
// per delivered byte, and the CRC unit folds in one data byte per cycle, while the output
// does not stall, as it leaves the chain, ready for the two CRC bytes. A one-word input
// buffer takes the next sample word while the current frame is still going out. An accepted
// sample word is first registered in that buffer, then loaded into the chain and the CRC
// unit, and only then is the first byte of its frame offered on the output.
module scope_frame_crc16_encoder_unit
    import sfce_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic signed [SAMPLE_W-1:0] sample_a,
    input  wire logic signed [SAMPLE_W-1:0] sample_b,
    input  wire logic signed [SAMPLE_W-1:0] sample_c,
    input  wire logic signed [SAMPLE_W-1:0] sample_d,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [BYTE_W-1:0]               frame_byte,
    output logic                            frame_end
);

    logic                hold_valid_reg;
    logic                hold_valid_next;
    logic                busy_reg;
    logic                busy_next;
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    idx_next;
    logic [SAMPLE_W-1:0] sample_a_reg;
    logic [SAMPLE_W-1:0] sample_b_reg;
    logic [SAMPLE_W-1:0] sample_c_reg;
    logic [SAMPLE_W-1:0] sample_d_reg;

    logic                in_fire;
    logic                out_fire;
    logic                last_fire;
    sfce_ctrl_t          ctrl;
    byte_t               load_bytes [DATA_BYTES];
    byte_t               chain      [DATA_BYTES+1];
    logic [CRC_W-1:0]    crc;

    assign out_fire  = busy_reg & ~out_stall;
    assign last_fire = out_fire & (idx_reg == IDX_CRC_HIGH);

    assign ctrl.load     = hold_valid_reg & (~busy_reg | last_fire);
    assign ctrl.shift    = out_fire & ~ctrl.load;
    assign ctrl.crc_step = out_fire & (idx_reg < IDX_CRC_LOW);

    assign in_stall = hold_valid_reg & ~ctrl.load;
    assign in_fire  = in_valid & ~in_stall;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (in_fire)
        begin
            hold_valid_next = 1'b1;
        end
        else if (ctrl.load)
        begin
            hold_valid_next = 1'b0;
        end

        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (ctrl.load)
        begin
            busy_next = 1'b1;
            idx_next  = IDX_FIRST;
        end
        else if (out_fire)
        begin
            idx_next = idx_reg + IDX_W'(1);
            if (last_fire)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            busy_reg       <= 1'b0;
            idx_reg        <= IDX_FIRST;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            busy_reg       <= busy_next;
            idx_reg        <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sample_a_reg <= $unsigned(sample_a);
            sample_b_reg <= $unsigned(sample_b);
            sample_c_reg <= $unsigned(sample_c);
            sample_d_reg <= $unsigned(sample_d);
        end
    end

    assign load_bytes[0] = sample_a_reg[BYTE_W-1:0];
    assign load_bytes[1] = sample_a_reg[SAMPLE_W-1:BYTE_W];
    assign load_bytes[2] = sample_b_reg[BYTE_W-1:0];
    assign load_bytes[3] = sample_b_reg[SAMPLE_W-1:BYTE_W];
    assign load_bytes[4] = sample_c_reg[BYTE_W-1:0];
    assign load_bytes[5] = sample_c_reg[SAMPLE_W-1:BYTE_W];
    assign load_bytes[6] = sample_d_reg[BYTE_W-1:0];
    assign load_bytes[7] = sample_d_reg[SAMPLE_W-1:BYTE_W];

    assign chain[DATA_BYTES] = '0;

    for (genvar i = 0; i < DATA_BYTES; i++)
    begin : g_cell
        sfce_cell u_cell
        (
            .clk         (clk),
            .ctrl        (ctrl),
            .load_in     (load_bytes[i]),
            .neighbor_in (chain[i+1]),
            .data_out    (chain[i])
        );
    end

    sfce_crc u_crc
    (
        .clk     (clk),
        .ctrl    (ctrl),
        .data_in (chain[0]),
        .crc     (crc)
    );

    always_comb
    begin
        if (idx_reg < IDX_CRC_LOW)
        begin
            frame_byte = chain[0];
        end
        else if (idx_reg == IDX_CRC_LOW)
        begin
            frame_byte = crc[BYTE_W-1:0];
        end
        else
        begin
            frame_byte = crc[CRC_W-1:BYTE_W];
        end
    end

    assign out_valid = busy_reg;
    assign frame_end = busy_reg & (idx_reg == IDX_CRC_HIGH);

`ifndef SYNTHESIS
    a_load_starts_frame: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load |=> (out_valid && idx_reg == IDX_FIRST))
        else $error("A frame did not start at its first byte after a load.");

    a_frame_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && idx_reg != IDX_CRC_HIGH) |=> out_valid)
        else $error("A frame stopped before its last byte.");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (last_fire && !hold_valid_reg) |=> !out_valid)
        else $error("Output stayed valid after the last byte with nothing buffered.");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (idx_reg <= IDX_CRC_HIGH))
        else $error("Byte index ran past the end of the frame.");

    a_accept_buffers: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> hold_valid_reg)
        else $error("An accepted sample word was not buffered.");
`endif

endmodule

`default_nettype wire

/* hw/rtl/sfce_cell.sv */
// One byte cell of the frame shift chain: loads in parallel, then hands its byte to its neighbor.
`default_nettype none

module sfce_cell
    import sfce_pkg::*;
(
    input  wire logic       clk,
    input  wire sfce_ctrl_t ctrl,
    input  wire byte_t      load_in,
    input  wire byte_t      neighbor_in,
    output byte_t           data_out
);

    byte_t data_reg;
    byte_t data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.load)
        begin
            data_next = load_in;
        end
        else if (ctrl.shift)
        begin
            data_next = neighbor_in;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;

endmodule

`default_nettype wire

/* hw/rtl/sfce_crc.sv */
// CRC-16 accumulator that folds in each data byte as it leaves the head of the chain.
`default_nettype none

module sfce_crc
    import sfce_pkg::*;
(
    input  wire logic             clk,
    input  wire sfce_ctrl_t       ctrl,
    input  wire byte_t            data_in,
    output logic [CRC_W-1:0]      crc
);

    logic [CRC_W-1:0] crc_reg;
    logic [CRC_W-1:0] crc_next;

    always_comb
    begin
        crc_next = crc_reg;
        if (ctrl.load)
        begin
            crc_next = CRC_INIT;
        end
        else if (ctrl.crc_step)
        begin
            crc_next = crc16_byte(crc_reg, data_in);
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg <= crc_next;
    end

    assign crc = crc_reg;

endmodule

`default_nettype wire
